// ----- src/koren_slope_limiter_assert.svh -----
// Assertion macros used by the checker module of the Koren slope limiter.
// Depends on nothing; included by the bound checker.
`ifndef KOREN_SLOPE_LIMITER_ASSERT_SVH
`define KOREN_SLOPE_LIMITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSLIM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSLIM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/kslim_pkg.sv -----
`timescale 1ns / 1ps
// Types and constants of the Koren slope limiter: payload structs, stage record, widths.
// Depends on nothing; imported by every module of the block.
package kslim_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PhiW     = FracBits + 2;
  localparam int unsigned DenW     = DataW + 1;
  localparam int unsigned ClampW   = FracBits + 3;
  localparam int unsigned XW       = FracBits + 4;
  localparam int unsigned ProdW    = PhiW + DataW;
  localparam int unsigned QW       = ProdW - FracBits;
  localparam int unsigned DivSteps = PhiW;
  localparam int unsigned LastStage = DivSteps + 2;
  localparam int unsigned NumStages = LastStage + 1;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned RegIdxW  = AddrW - 2;

  localparam logic [RegIdxW-1:0] RegIdxUpperBound = RegIdxW'(0);

  localparam logic [DenW-1:0]   OneDen    = DenW'(1) << FracBits;
  localparam logic [XW-1:0]     OneX      = XW'(1) << FracBits;
  localparam logic [ClampW-1:0] ClampMax  = ClampW'(4) << FracBits;
  localparam logic [PhiW-1:0]   PhiMax    = PhiW'(2) << FracBits;
  localparam logic [XW-1:0]     Recip3    = XW'((64'(1) << XW) / 3);
  localparam logic [QW-1:0]     QNegLimit = QW'(64'h8000_0000);
  localparam logic [QW-1:0]     QPosLimit = QW'(64'h7FFF_FFFF);
  localparam logic [DataW-1:0]  SatPos    = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0]  SatNeg    = 32'h8000_0000;

  typedef struct packed {
    logic signed [DataW-1:0] slope_ratio;
    logic signed [DataW-1:0] raw_gradient;
  } kslim_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] limited_gradient;
    logic [PhiW-1:0]         limiter_value;
    logic                    saturated;
  } kslim_out_t;

  typedef struct packed {
    logic              pos;
    logic              ube;
    logic              neg;
    logic [DataW-1:0]  mag;
    logic [XW-1:0]     twice;
    logic [XW-1:0]     num3;
    logic [2*XW-1:0]   prod3;
    logic [PhiW-1:0]   phi;
    logic [DenW-1:0]   den;
    logic [DenW-1:0]   rem;
    logic [PhiW-1:0]   quo;
    logic [ProdW-1:0]  prod;
  } kslim_stage_t;

endpackage

// ----- src/koren_slope_limiter.sv -----
`timescale 1ns / 1ps
// Top level of the Koren slope limiter: entry stage, divider and multiplier pipeline.
// Depends on kslim_pkg and kslim_regs.
//
// Each input transaction carries a slope ratio r and a gradient g, both signed Q16.16.
// Each output transaction carries phi(r)*g (saturated Q16.16), phi(r) in unsigned
// Q2.16 and a saturation flag; there is exactly one output per input, in order.
// Both channels use valid and stall; a transaction moves when valid is high and
// stall is low. The APB port holds one register, the upper bound enable, at
// address 0; the user must write it only while the pipeline is empty, which
// the block itself does not enforce. One transaction is accepted every cycle
// while input stall is low. The pipeline is built around the restoring divider
// for 4/(1+r), which resolves one quotient bit per stage over 18 stages,
// followed by the limiter select, the multiplier and the saturation stage.
// Reset clears all valid bits and sets the upper bound enable to one.
// When the receiver stalls, the output register holds; stages behind it keep
// advancing into empty slots, so input stall is raised only once every stage
// holds a transaction.
module koren_slope_limiter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  kslim_pkg::kslim_in_t        in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output kslim_pkg::kslim_out_t       out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kslim_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import kslim_pkg::*;

  logic                 ube;
  kslim_stage_t         st_q [NumStages];
  kslim_stage_t         st_d [NumStages];
  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   rdy;
  kslim_out_t           out_q, out_d;
  logic                 out_valid_q;

  logic [DataW-2:0]     r_mag;
  logic [ClampW-1:0]    r_clamp;
  logic [QW-1:0]        q_shift;

  kslim_regs u_kslim_regs (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .upper_bound_enable_o (ube)
  );

  assign rdy[NumStages] = !out_valid_q || !out_stall_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  assign in_stall_o = !rdy[0];

  // Entry stage: sign handling, clamping of r and the divisor 1 + r.
  assign r_mag   = in_data_i.slope_ratio[DataW-2:0];
  assign r_clamp = (r_mag >= (DataW-1)'(ClampMax)) ? ClampMax : r_mag[ClampW-1:0];

  always_comb begin
    st_d[0]       = '0;
    st_d[0].pos   = !in_data_i.slope_ratio[DataW-1] && (in_data_i.slope_ratio != '0);
    st_d[0].ube   = ube;
    st_d[0].neg   = in_data_i.raw_gradient[DataW-1];
    st_d[0].mag   = in_data_i.raw_gradient[DataW-1] ?
                    DataW'(~in_data_i.raw_gradient + 1'b1) : DataW'(in_data_i.raw_gradient);
    st_d[0].twice = {r_clamp, 1'b0};
    st_d[0].num3  = OneX + {r_clamp, 1'b0};
    st_d[0].den   = {1'b0, in_data_i.slope_ratio} + OneDen;
    st_d[0].rem   = OneDen;
  end

  for (genvar k = 1; k < NumStages; k++) begin : g_stage
    logic [DenW:0]   trial;
    logic [XW-1:0]   quot3;
    logic [XW+1:0]   rest3;
    logic [XW-1:0]   smin;

    always_comb begin
      trial = {st_q[k-1].rem, 1'b0};
      quot3 = st_q[k-1].prod3[2*XW-1:XW];
      rest3 = (XW+2)'(st_q[k-1].num3) - ((XW+2)'(quot3) + ((XW+2)'(quot3) << 1));
      smin  = (st_q[k-1].twice < XW'(st_q[k-1].phi)) ? st_q[k-1].twice
                                                     : XW'(st_q[k-1].phi);
      st_d[k] = st_q[k-1];
      if (k <= DivSteps) begin
        if (trial >= {1'b0, st_q[k-1].den}) begin
          st_d[k].rem = DenW'(trial - {1'b0, st_q[k-1].den});
          st_d[k].quo = {st_q[k-1].quo[PhiW-2:0], 1'b1};
        end else begin
          st_d[k].rem = trial[DenW-1:0];
          st_d[k].quo = {st_q[k-1].quo[PhiW-2:0], 1'b0};
        end
      end
      if (k == 1) begin
        st_d[k].prod3 = (2*XW)'(st_q[k-1].num3) * (2*XW)'(Recip3);
      end
      if (k == 2) begin
        st_d[k].phi = (rest3 >= (XW+2)'(3)) ? PhiW'(quot3 + 1'b1) : PhiW'(quot3);
      end
      if (k == 3) begin
        if (!st_q[k-1].pos) begin
          st_d[k].phi = '0;
        end else if (smin > XW'(PhiMax)) begin
          st_d[k].phi = PhiMax;
        end else begin
          st_d[k].phi = PhiW'(smin);
        end
      end
      if (k == DivSteps + 1) begin
        if (st_q[k-1].ube && st_q[k-1].pos && (st_q[k-1].quo < st_q[k-1].phi)) begin
          st_d[k].phi = st_q[k-1].quo;
        end
      end
      if (k == DivSteps + 2) begin
        st_d[k].prod = ProdW'(st_q[k-1].phi) * ProdW'(st_q[k-1].mag);
      end
    end
  end

  // Output stage: truncate the magnitude, restore the sign and saturate.
  assign q_shift = st_q[LastStage].prod[ProdW-1:FracBits];

  always_comb begin
    out_d.limiter_value = st_q[LastStage].phi;
    out_d.saturated     = 1'b0;
    if (st_q[LastStage].neg) begin
      if (q_shift > QNegLimit) begin
        out_d.limited_gradient = SatNeg;
        out_d.saturated        = 1'b1;
      end else begin
        out_d.limited_gradient = DataW'(~q_shift[DataW-1:0] + 1'b1);
      end
    end else begin
      if (q_shift > QPosLimit) begin
        out_d.limited_gradient = SatPos;
        out_d.saturated        = 1'b1;
      end else begin
        out_d.limited_gradient = q_shift[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int unsigned k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (rdy[NumStages]) begin
        out_valid_q <= v_q[LastStage];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned k = 0; k < NumStages; k++) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
    if (rdy[NumStages]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/kslim_regs.sv -----
`timescale 1ns / 1ps
// APB configuration register of the Koren slope limiter (upper bound enable).
// Depends on kslim_pkg.
module kslim_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kslim_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic                        upper_bound_enable_o
);
  import kslim_pkg::*;

  logic ube_q, ube_d;
  logic sel_ube;

  assign sel_ube = (paddr[AddrW-1:2] == RegIdxUpperBound);
  assign pready  = 1'b1;

  always_comb begin
    ube_d = ube_q;
    if (psel && penable && pwrite && sel_ube) begin
      ube_d = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_ube) begin
      prdata[0] = ube_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ube_q <= 1'b1;
    end else begin
      ube_q <= ube_d;
    end
  end

  assign upper_bound_enable_o = ube_q;

endmodule

// ----- src/kslim_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the Koren slope limiter and its bind to the top level.
// Depends on kslim_pkg and koren_slope_limiter_assert.svh.
`include "koren_slope_limiter_assert.svh"

module kslim_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input kslim_pkg::kslim_out_t       out_data_o
);
  import kslim_pkg::*;

  kslim_out_t out_prev_q;
  logic       out_held;
  logic       out_kept;
  logic       out_free;
  logic       in_free;
  logic       phi_ok;
  logic       sat_out;
  logic       at_limit;
  logic       zero_out;
  logic       zero_clean;

  always_ff @(posedge clk_i) begin
    out_prev_q <= out_data_o;
  end

  assign out_held   = out_valid_o && out_stall_i;
  assign out_kept   = out_valid_o && (out_data_o == out_prev_q);
  assign out_free   = !out_stall_i;
  assign in_free    = !in_stall_o;
  assign phi_ok     = out_data_o.limiter_value <= PhiMax;
  assign sat_out    = out_valid_o && out_data_o.saturated;
  assign at_limit   = (out_data_o.limited_gradient == SatPos) ||
                      (out_data_o.limited_gradient == SatNeg);
  assign zero_out   = out_valid_o && (out_data_o.limiter_value == '0);
  assign zero_clean = (out_data_o.limited_gradient == '0) && !out_data_o.saturated;

  `KSLIM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_kept, "stalled output changed")
  `KSLIM_ASSERT_NOW(a_stall_path, clk_i, rst_ni, out_free, in_free, "input stalled needlessly")
  `KSLIM_ASSERT_NOW(a_phi_range, clk_i, rst_ni, out_valid_o, phi_ok, "limiter value above two")
  `KSLIM_ASSERT_NOW(a_sat_value, clk_i, rst_ni, sat_out, at_limit, "saturation off range limit")
  `KSLIM_ASSERT_NOW(a_zero_phi, clk_i, rst_ni, zero_out, zero_clean, "zero limiter gave a result")

endmodule

bind koren_slope_limiter kslim_checker u_kslim_checker (.*);

// ----- bench/tb_koren_slope_limiter.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the Koren slope limiter: corner and random slope ratio and gradient
// transactions, with every result predicted in the bench and compared in order.
// Depends on kslim_pkg and koren_slope_limiter.
module tb_koren_slope_limiter;
  import kslim_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 30;
  localparam logic [AddrW-1:0] UbeAddr = {RegIdxUpperBound, 2'b00};
  localparam logic [AddrW-1:0] UnmappedAddr = AddrW'(4);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  kslim_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  kslim_out_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  kslim_in_t pending_items[$];
  kslim_out_t awaited_results[$];
  logic ube_cfg = 1'b1;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int unsigned gap_max = 0;
  int unsigned stall_max = 0;
  int unsigned send_gap = 0;
  int unsigned recv_wait = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;

  koren_slope_limiter DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #6 clk_i = ~clk_i;

  function automatic kslim_out_t limit_gradient(input kslim_in_t item, input logic bound_on);
    logic [63:0] one, ratio, twice, smooth, phi, bound, grad_ext, mag, q;
    logic neg;
    kslim_out_t res;
    one = 64'd1 << FracBits;
    phi = '0;
    if (!item.slope_ratio[DataW-1] && item.slope_ratio != '0) begin
      ratio = {32'd0, item.slope_ratio};
      twice = ratio << 1;
      smooth = (one + twice) / 64'd3;
      phi = (smooth < twice) ? smooth : twice;
      if (phi > (one << 1)) phi = one << 1;
      if (bound_on) begin
        bound = (64'd4 << (2 * FracBits)) / (one + ratio);
        if (bound < phi) phi = bound;
      end
    end
    neg = item.raw_gradient[DataW-1];
    grad_ext = {{32{neg}}, item.raw_gradient};
    mag = neg ? 64'd0 - grad_ext : grad_ext;
    q = (phi * mag) >> FracBits;
    res.saturated = 1'b0;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        res.limited_gradient = SatNeg;
        res.saturated = 1'b1;
      end else begin
        res.limited_gradient = DataW'(64'd0 - q);
      end
    end else if (q > 64'h7FFF_FFFF) begin
      res.limited_gradient = SatPos;
      res.saturated = 1'b1;
    end else begin
      res.limited_gradient = DataW'(q);
    end
    res.limiter_value = phi[PhiW-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin : monitor
    kslim_out_t want;
    if (rst_ni) begin
      in_fire <= in_valid_i && !in_stall_o;
      out_fire <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o) begin
        awaited_results.push_back(limit_gradient(in_data_i, ube_cfg));
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("Unexpected result transaction: %h", out_data_o);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data_o.limited_gradient !== want.limited_gradient) begin
            $error("limited_gradient: expected %h, actual %h",
                   want.limited_gradient, out_data_o.limited_gradient);
            fail_count++;
          end
          if (out_data_o.limiter_value !== want.limiter_value) begin
            $error("limiter_value: expected %h, actual %h",
                   want.limiter_value, out_data_o.limiter_value);
            fail_count++;
          end
          if (out_data_o.saturated !== want.saturated) begin
            $error("saturated: expected %b, actual %b", want.saturated, out_data_o.saturated);
            fail_count++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  always @(negedge clk_i) begin : feeder
    logic next_valid;
    kslim_in_t next_item;
    next_valid = in_valid_i && !in_fire;
    next_item = in_data_i;
    if (rst_ni && !next_valid) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        next_valid = 1'b1;
        send_gap = $urandom_range(0, gap_max);
      end
    end
    in_valid_i <= next_valid;
    in_data_i <= next_item;
  end

  always @(negedge clk_i) begin : receiver
    logic stall_next;
    if (out_fire) recv_wait = $urandom_range(0, stall_max);
    stall_next = rst_ni && recv_wait != 0;
    if (out_valid_o && recv_wait != 0) recv_wait--;
    out_stall_i <= stall_next;
  end

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (wr && addr == UbeAddr) ube_cfg = wdata[0];
  endtask

  task automatic check_bound_register();
    logic [31:0] readback;
    apb_access(1'b0, UbeAddr, '0, readback);
    if (readback !== {31'd0, ube_cfg}) begin
      $error("upper_bound_enable: expected %h, actual %h", {31'd0, ube_cfg}, readback);
      fail_count++;
    end
  endtask

  task automatic write_register(input logic [AddrW-1:0] addr, input logic [31:0] value);
    logic [31:0] unused_rdata;
    apb_access(1'b1, addr, value, unused_rdata);
    check_bound_register();
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || in_valid_i || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_corners();
    logic [31:0] ratios[12];
    logic [31:0] grads[12];
    kslim_in_t item;
    ratios = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h0000_0001, 32'h0000_8000, 32'h0001_0000, 32'h0002_0000,
               32'h0002_0000, 32'h0004_0000, 32'h7FFF_FFFF, 32'h0002_0000};
    grads  = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h0001_0000, 32'h8000_0000, 32'hC000_0000};
    for (int k = 0; k < 12; k++) begin
      item.slope_ratio = ratios[k];
      item.raw_gradient = grads[k];
      pending_items.push_back(item);
    end
  endtask

  task automatic queue_random(input int unsigned count);
    logic [31:0] ratio, grad, base;
    kslim_in_t item;
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(0, 7))
        0, 1: ratio = $urandom;
        2, 3: ratio = $urandom_range(1, 32'h0008_0000);
        4: begin
          case ($urandom_range(0, 3))
            0: base = 32'h0000_4000;
            1: base = 32'h0001_0000;
            2: base = 32'h0001_B64A;
            default: base = 32'h0002_8000;
          endcase
          ratio = base + $urandom_range(0, 64) - 32;
        end
        5: ratio = $urandom_range(0, 3) == 0 ? 32'd0 : {1'b1, 31'($urandom)};
        default: ratio = $urandom_range(1, 32'h0100_0000);
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2, 3: grad = $urandom;
        4, 5: grad = {1'($urandom), 31'($urandom) | 31'h4000_0000};
        6: begin
          grad = $urandom_range(0, 32'h0002_0000);
          if ($urandom_range(0, 1) == 1) grad = -grad;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: grad = 32'h7FFF_FFFF;
            1: grad = 32'h8000_0000;
            2: grad = 32'h0000_0000;
            default: grad = 32'hFFFF_FFFF;
          endcase
        end
      endcase
      item.slope_ratio = ratio;
      item.raw_gradient = grad;
      pending_items.push_back(item);
    end
  endtask

  initial begin : sequencer
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_bound_register();
    queue_corners();
    settle();
    write_register(UbeAddr, 32'h0000_0000);
    gap_max = 3;
    stall_max = 3;
    queue_corners();
    settle();
    write_register(UnmappedAddr, 32'hFFFF_FFFF);
    gap_max = 8;
    stall_max = 8;
    queue_random(110);
    settle();
    write_register(UbeAddr, 32'hFFFF_FFFF);
    gap_max = 0;
    stall_max = 0;
    queue_random(110);
    settle();
    write_register(UbeAddr, 32'h0000_0002);
    gap_max = 8;
    stall_max = 0;
    queue_random(100);
    settle();
    write_register(UbeAddr, 32'h0000_0001);
    gap_max = 0;
    stall_max = 8;
    queue_random(110);
    settle();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    wait (idle_cycles >= IdleLimit);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
